[src/swd_pkg.sv]
// shared types and constants of the stream word deleter
package swd_pkg;

  localparam int unsigned PatternMaxDef = 8;
  localparam int unsigned CharW         = 8;
  localparam int unsigned LenW          = 4;
  localparam int unsigned PatW          = 64;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_PATTERN_CHARS  = 1'b0,
    REG_PATTERN_LENGTH = 1'b1
  } cfg_reg_e;

  // per-cycle command to every window cell
  typedef struct packed {
    logic pre_shift;   // take the neighbour's stored character before the compare
    logic post_shift;  // take the neighbour's compared character after the compare
    logic load;        // take the incoming text character
  } cell_cmd_t;

  // one result of the filtered text
  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             valid;
    logic             done;
  } result_t;

endpackage

[src/swd_cell.sv]
// one window cell: holds a character, compares it and passes it to its neighbour
module swd_cell (
  input  logic                       clk_i,
  input  swd_pkg::cell_cmd_t         cmd_i,
  input  logic [swd_pkg::CharW-1:0]  new_char_i,
  input  logic [swd_pkg::CharW-1:0]  nb_char_i,
  input  logic [swd_pkg::CharW-1:0]  nb_view_i,
  input  logic [swd_pkg::CharW-1:0]  pat_char_i,
  input  logic                       in_word_i,
  output logic [swd_pkg::CharW-1:0]  char_o,
  output logic [swd_pkg::CharW-1:0]  view_o,
  output logic                       hit_o
);

  logic [swd_pkg::CharW-1:0] char_q, char_d;

  // character seen by the compare in this cycle
  always_comb begin
    priority if (cmd_i.load) begin
      view_o = new_char_i;
    end else if (cmd_i.pre_shift) begin
      view_o = nb_char_i;
    end else begin
      view_o = char_q;
    end
  end

  assign hit_o  = !in_word_i || (view_o == pat_char_i);
  assign char_d = cmd_i.post_shift ? nb_view_i : view_o;
  assign char_o = char_q;

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
  end

endmodule

[src/swd_out_q.sv]
// two-entry result queue between the window and the output channel
module swd_out_q (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  swd_pkg::result_t  push_data_i,
  output logic              full_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output swd_pkg::result_t  head_o
);

  swd_pkg::result_t entry_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  logic       pop;

  assign out_valid_o = (cnt_q != 2'd0);
  assign full_o      = (cnt_q == 2'd2);
  assign pop         = out_valid_o && !out_stall_i;
  assign head_o      = entry_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

[src/stream_word_deleter_top.sv]
// top level of the stream word deleter: window cell chain, control and result queue
//
//   channel   direction  handshake               payload
//   in        request    in_valid_i / in_stall_o   text_char_i, end_of_text_i
//   out       result     out_valid_o / out_stall_i out_char_o, char_valid_o, text_done_o
//   cfg       write      cfg_we_i                  cfg_index_i, cfg_data_i
//
// one request per cycle in steady state while the result queue has room; a request passes through a holding register
// and the cell chain, and its result is registered in the result queue before it reaches the output
// the end of a text drains the window one character per cycle while the result queue has room,
// and a shortened word drains the surplus characters the same way before the new one
// the two-entry result queue lets requests keep flowing while one result waits
// reset empties the window and sets the word to one zero byte; no clearing pass is needed
// a full result queue halts the window; input stall rises while a held request is not consumed
module stream_word_deleter_top #(
  parameter int unsigned PATTERN_MAX = swd_pkg::PatternMaxDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // text requests
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [swd_pkg::CharW-1:0]  text_char_i,
  input  logic                       end_of_text_i,
  // results
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [swd_pkg::CharW-1:0]  out_char_o,
  output logic                       char_valid_o,
  output logic                       text_done_o,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [0:0]                 cfg_index_i,
  input  logic [swd_pkg::PatW-1:0]   cfg_data_i
);

  localparam int unsigned FillW = $clog2(PATTERN_MAX + 1);
  localparam logic [swd_pkg::LenW-1:0] LenMax = swd_pkg::LenW'(PATTERN_MAX);

  // where the incoming character enters the window
  typedef enum logic [1:0] {
    LOAD_NONE,
    LOAD_AT_TOP,
    LOAD_AT_FILL
  } load_sel_e;

  // configuration registers
  logic [swd_pkg::PatW-1:0] pat_chars_q;
  logic [swd_pkg::LenW-1:0] pat_len_q;
  logic [swd_pkg::LenW-1:0] len;

  // control state
  logic [FillW-1:0] fill_q, fill_d;
  logic             flush_q, flush_d;
  logic             popx_q, popx_d;
  logic             px_last_q, px_last_d;
  logic             pend_valid_q, pend_valid_d;
  logic [swd_pkg::CharW-1:0] pend_char_q;
  logic             pend_last_q;

  logic [swd_pkg::LenW-1:0] fill_w, fill_inc;
  logic             go, consume, accept, match;
  logic             pre_shift, post_shift;
  load_sel_e        load_sel;
  logic             push, q_full;
  swd_pkg::result_t push_data, head;
  swd_pkg::cell_cmd_t cell_cmd [PATTERN_MAX];

  logic [swd_pkg::CharW-1:0] cell_char [PATTERN_MAX];
  logic [swd_pkg::CharW-1:0] cell_view [PATTERN_MAX];
  logic [PATTERN_MAX-1:0]    cell_hit;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_chars_q <= '0;
      pat_len_q   <= swd_pkg::LenW'(1);
    end else if (cfg_we_i) begin
      unique case (swd_pkg::cfg_reg_e'(cfg_index_i))
        swd_pkg::REG_PATTERN_CHARS:  pat_chars_q <= cfg_data_i;
        swd_pkg::REG_PATTERN_LENGTH: pat_len_q   <= cfg_data_i[swd_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  // effective word length, zero taken as one and clipped to the window size
  always_comb begin
    priority if (pat_len_q == '0) begin
      len = swd_pkg::LenW'(1);
    end else if (pat_len_q > LenMax) begin
      len = LenMax;
    end else begin
      len = pat_len_q;
    end
  end

  assign fill_w   = swd_pkg::LenW'(fill_q);
  assign fill_inc = fill_w + swd_pkg::LenW'(1);
  assign go       = !q_full;
  assign match    = &cell_hit;

  // cell chain: cell 0 holds the oldest pending character
  for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_cell
    logic [swd_pkg::CharW-1:0] nb_char, nb_view;
    logic                      load_here;

    if (k == PATTERN_MAX - 1) begin : g_end
      assign nb_char = '0;
      assign nb_view = '0;
    end else begin : g_mid
      assign nb_char = cell_char[k+1];
      assign nb_view = cell_view[k+1];
    end

    always_comb begin
      unique case (load_sel)
        LOAD_AT_TOP:  load_here = (swd_pkg::LenW'(k) == len - swd_pkg::LenW'(1));
        LOAD_AT_FILL: load_here = (swd_pkg::LenW'(k) == fill_w);
        default:      load_here = 1'b0;
      endcase
    end

    assign cell_cmd[k] = '{pre_shift: pre_shift, post_shift: post_shift, load: load_here};

    swd_cell u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cell_cmd[k]),
      .new_char_i (pend_char_q),
      .nb_char_i  (nb_char),
      .nb_view_i  (nb_view),
      .pat_char_i (pat_chars_q[swd_pkg::CharW*k +: swd_pkg::CharW]),
      .in_word_i  (swd_pkg::LenW'(k) < len),
      .char_o     (cell_char[k]),
      .view_o     (cell_view[k]),
      .hit_o      (cell_hit[k])
    );
  end

  // one window operation per cycle while the result queue is not full
  always_comb begin
    fill_d     = fill_q;
    flush_d    = flush_q;
    popx_d     = popx_q;
    px_last_d  = px_last_q;
    pre_shift  = 1'b0;
    post_shift = 1'b0;
    load_sel   = LOAD_NONE;
    push       = 1'b0;
    push_data  = '{ch: cell_char[0], valid: 1'b1, done: 1'b0};
    consume    = 1'b0;

    if (go) begin
      priority if (flush_q) begin
        // end of text: drain the window, last character carries the end mark
        pre_shift      = 1'b1;
        push           = 1'b1;
        push_data.done = (fill_w == swd_pkg::LenW'(1));
        fill_d         = fill_q - FillW'(1);
        flush_d        = (fill_w != swd_pkg::LenW'(1));
      end else if (popx_q) begin
        // full window that failed the compare: pass on its oldest character
        pre_shift      = 1'b1;
        push           = 1'b1;
        push_data.done = px_last_q && (fill_w == swd_pkg::LenW'(1));
        fill_d         = fill_q - FillW'(1);
        popx_d         = 1'b0;
        flush_d        = px_last_q && (fill_w > swd_pkg::LenW'(1));
      end else if (pend_valid_q) begin
        priority if (fill_w > len) begin
          // word shortened: surplus characters leave first
          pre_shift = 1'b1;
          push      = 1'b1;
          fill_d    = fill_q - FillW'(1);
        end else if (fill_w == len) begin
          // oldest leaves and the new character enters at the top in one go
          consume        = 1'b1;
          pre_shift      = 1'b1;
          load_sel       = LOAD_AT_TOP;
          push           = 1'b1;
          if (match) begin
            fill_d         = '0;
            push_data.done = pend_last_q;
          end else begin
            popx_d    = 1'b1;
            px_last_d = pend_last_q;
          end
        end else begin
          // ordinary case: append; once the word length is reached, drop the word or pass on the oldest
          consume  = 1'b1;
          load_sel = LOAD_AT_FILL;
          if (fill_inc == len) begin
            if (match) begin
              fill_d = '0;
              if (pend_last_q) begin
                push      = 1'b1;
                push_data = '{ch: '0, valid: 1'b0, done: 1'b1};
              end
            end else begin
              post_shift     = 1'b1;
              push           = 1'b1;
              push_data.ch   = cell_view[0];
              push_data.done = pend_last_q && (len == swd_pkg::LenW'(1));
              fill_d         = FillW'(len - swd_pkg::LenW'(1));
              flush_d        = pend_last_q && (len != swd_pkg::LenW'(1));
            end
          end else begin
            fill_d  = FillW'(fill_inc);
            flush_d = pend_last_q;
          end
        end
      end
    end
  end

  // holding register for the request being worked on
  assign in_stall_o   = pend_valid_q && !consume;
  assign accept       = in_valid_i && !in_stall_o;
  assign pend_valid_d = accept || (pend_valid_q && !consume);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q       <= '0;
      flush_q      <= 1'b0;
      popx_q       <= 1'b0;
      px_last_q    <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      fill_q       <= fill_d;
      flush_q      <= flush_d;
      popx_q       <= popx_d;
      px_last_q    <= px_last_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_char_q <= text_char_i;
      pend_last_q <= end_of_text_i;
    end
  end

  swd_out_q u_out_q (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (q_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .head_o      (head)
  );

  assign out_char_o   = head.ch;
  assign char_valid_o = head.valid;
  assign text_done_o  = head.done;

`ifndef NO_ASSERTIONS
  a_drain_modes_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(flush_q && popx_q))
    else $error("flush and extra pop active together");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_w <= LenMax)
    else $error("window fill beyond window size");

  a_flush_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (fill_q != '0))
    else $error("flush running on an empty window");

  a_no_queue_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !q_full)
    else $error("result pushed into a full queue");

  a_drain_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_valid_q && (flush_q || popx_q)) |-> in_stall_o)
    else $error("request taken while the window drains");
`endif

endmodule
